### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### rtl/tsrc_pkg.sv
// ----------------------------------------------------------------------------
// tsrc_pkg
// shared types and constants of the slot reservation checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tsrc_pkg;

  localparam int WORD_W   = 32;  // map bits per memory word
  localparam int BIT_W    = 5;   // bit index within a word
  localparam int FIELD_W  = 21;  // time fields of a word
  localparam int TIME_W   = 26;  // room for horizon plus one period

  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_ONCE     = 2'd1;
  localparam logic [1:0] KIND_PERIODIC = 2'd2;

  typedef enum logic [1:0] {
    RMW_IDLE,
    RMW_CLEAR,
    RMW_SWEEP
  } rmw_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_ISSUE,
    T_WAIT,
    T_FIN
  } top_state_t;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
  } rmw_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } rmw_stat_t;

endpackage

### rtl/tsrc_ram.sv
// ----------------------------------------------------------------------------
// tsrc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tsrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tsrc_rmw.sv
// ----------------------------------------------------------------------------
// tsrc_rmw
// occupancy map memory with word sweep: clear pass or window reservation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsrc_rmw import tsrc_pkg::*; #(
  parameter int HORIZON = 1048576
) (
  input  logic      clk,
  input  logic      rst,
  input  rmw_cmd_t  cmd,
  output rmw_stat_t stat
);

  localparam int WORDS = (HORIZON + WORD_W - 1) / WORD_W;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  rmw_state_t state, state_next;

  logic [AW-1:0]     cur_w, first_w, last_w, p_addr;
  logic [BIT_W-1:0]  lo_b, hi_b;
  logic              more, p_valid, done, hit;

  logic [TIME_W-1:0] hi_m1;
  logic              empty;
  logic [BIT_W-1:0]  lo_sel, hi_sel;
  logic [WORD_W-1:0] mask, rdata;
  logic              overlap;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata;

  tsrc_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign hi_m1 = cmd.hi - TIME_W'(1);
  assign empty = (cmd.lo >= cmd.hi);

  // bits of the current word that fall inside the window
  assign lo_sel  = (p_addr == first_w) ? lo_b : '0;
  assign hi_sel  = (p_addr == last_w) ? hi_b : '1;
  assign mask    = ({WORD_W{1'b1}} << lo_sel) &
                   ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_sel));
  assign overlap = p_valid && (|(rdata & mask));

  always_comb begin
    state_next = state;
    case (state)
      RMW_IDLE: begin
        if (cmd.start) begin
          if (cmd.clear) begin
            state_next = RMW_CLEAR;
          end else if (!empty) begin
            state_next = RMW_SWEEP;
          end
        end
      end
      RMW_CLEAR: begin
        if (cur_w == LAST_WORD) begin
          state_next = RMW_IDLE;
        end
      end
      RMW_SWEEP: begin
        if (p_valid && (overlap || p_addr == last_w)) begin
          state_next = RMW_IDLE;
        end
      end
      default: state_next = RMW_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_w;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur_w;
    case (state)
      RMW_CLEAR: begin
        ram_we = 1'b1;
      end
      RMW_SWEEP: begin
        ram_re = more;
        if (p_valid && !overlap) begin
          ram_we    = 1'b1;
          ram_waddr = p_addr;
          ram_wdata = rdata | mask;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= RMW_IDLE;
      more    <= 1'b0;
      p_valid <= 1'b0;
      done    <= 1'b0;
      hit     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        RMW_IDLE: begin
          // an empty window finishes at once
          done <= cmd.start && !cmd.clear && empty;
          if (cmd.start) begin
            hit <= 1'b0;
            if (cmd.clear) begin
              cur_w <= '0;
            end else if (!empty) begin
              cur_w   <= cmd.lo[AW+BIT_W-1:BIT_W];
              first_w <= cmd.lo[AW+BIT_W-1:BIT_W];
              last_w  <= hi_m1[AW+BIT_W-1:BIT_W];
              lo_b    <= cmd.lo[BIT_W-1:0];
              hi_b    <= hi_m1[BIT_W-1:0];
              more    <= 1'b1;
              p_valid <= 1'b0;
            end
          end
        end
        RMW_CLEAR: begin
          cur_w <= cur_w + AW'(1);
          done  <= (cur_w == LAST_WORD);
        end
        RMW_SWEEP: begin
          p_addr <= cur_w;
          if (more) begin
            cur_w <= cur_w + AW'(1);
          end
          if (overlap) begin
            hit     <= 1'b1;
            done    <= 1'b1;
            more    <= 1'b0;
            p_valid <= 1'b0;
          end else if (p_valid && p_addr == last_w) begin
            done    <= 1'b1;
            p_valid <= 1'b0;
          end else begin
            done    <= 1'b0;
            p_valid <= more;
            if (more) begin
              more <= (cur_w != last_w);
            end
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  assign stat.busy = (state != RMW_IDLE);
  assign stat.done = done;
  assign stat.hit  = hit;

  `ASSERT_CLK(a_no_rw_same_word, clk, rst, (ram_we && ram_re) |-> ram_waddr != ram_raddr)
  `ASSERT_CLK(a_pipe_in_sweep, clk, rst, p_valid |-> state == RMW_SWEEP)
  `ASSERT_CLK(a_done_when_idle, clk, rst, done |-> state == RMW_IDLE)
  `ASSERT_NEVER(a_clear_no_read, clk, rst, state == RMW_CLEAR && ram_re)

endmodule

### rtl/time_slot_reservation_conflict.sv
// ----------------------------------------------------------------------------
// time_slot_reservation_conflict
// a clear word runs one clearing pass over the whole map; a task word runs one
//   window pass, or one per period for a periodic word, over its 32-slot map words
// throughput: one word at a time, the next accepted only after the last one ends;
//   one map read-modify-write per cycle
// reset: synchronous; a clearing pass over the whole map runs, in_ready low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module time_slot_reservation_conflict import tsrc_pkg::*; #(
  parameter int HORIZON = 1048576
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [FIELD_W-1:0] start_time,
  input  logic [FIELD_W-1:0] end_time,
  input  logic [FIELD_W-1:0] period,
  input  logic               last_task,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               conflict
);

  localparam logic [TIME_W-1:0] HOR_T = TIME_W'(HORIZON);

  top_state_t state, state_next;

  // latched word; s and e advance by one period per pass, e clamped to the horizon
  logic [1:0]         kind_r;
  logic [TIME_W-1:0]  s_r, e_r;
  logic [FIELD_W-1:0] p_r;
  logic               last_r;
  logic               conflict_seen;

  logic [TIME_W-1:0]  e_clamp, e_sum, e_next;
  logic               go;
  logic               out_free;

  rmw_cmd_t  cmd;
  rmw_stat_t stat;

  tsrc_rmw #(.HORIZON(HORIZON)) u_rmw (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // window end is clamped to the horizon on every pass
  assign e_clamp = (e_r > HOR_T) ? HOR_T : e_r;
  assign e_sum   = e_clamp + TIME_W'(p_r);
  assign e_next  = (e_sum > HOR_T) ? HOR_T : e_sum;

  // output slot can take a new result this cycle
  assign out_free = !out_valid || out_ready;

  // does this pass touch the map at all
  always_comb begin
    case (kind_r)
      KIND_CLEAR:    go = 1'b1;
      KIND_ONCE:     go = !conflict_seen;
      KIND_PERIODIC: go = !conflict_seen && (s_r < HOR_T);
      default:       go = 1'b0;  // unused kind reserves nothing
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (in_valid) begin
          state_next = T_ISSUE;
        end
      end
      T_ISSUE: begin
        state_next = go ? T_WAIT : T_FIN;
      end
      T_WAIT: begin
        if (stat.done) begin
          // another periodic pass unless overlap found or period is zero
          if (kind_r == KIND_PERIODIC && !stat.hit && p_r != '0) begin
            state_next = T_ISSUE;
          end else begin
            state_next = T_FIN;
          end
        end
      end
      T_FIN: begin
        if (!last_r || out_free) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd.start = 1'b0;
    cmd.clear = (kind_r == KIND_CLEAR);
    cmd.lo    = s_r;
    cmd.hi    = e_clamp;
    case (state)
      T_IDLE:  in_ready  = 1'b1;
      T_ISSUE: cmd.start = go;
      default: in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // reset runs a clear pass over the whole map before the first word
      state         <= T_ISSUE;
      kind_r        <= KIND_CLEAR;
      last_r        <= 1'b0;
      conflict_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      // result register: load from the final state of a last word, else drop once taken
      if (state == T_FIN && last_r && out_free) begin
        out_valid <= 1'b1;
        conflict  <= conflict_seen;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        T_IDLE: begin
          if (in_valid) begin
            kind_r <= kind;
            s_r    <= TIME_W'(start_time);
            e_r    <= TIME_W'(end_time);
            p_r    <= period;
            last_r <= last_task;
          end
        end
        T_ISSUE: begin
          if (kind_r == KIND_CLEAR) begin
            conflict_seen <= 1'b0;
          end
        end
        T_WAIT: begin
          if (stat.done) begin
            if (stat.hit) begin
              conflict_seen <= 1'b1;
            end
            s_r <= s_r + TIME_W'(p_r);
            e_r <= e_next;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_done_in_wait, clk, rst, stat.done |-> state == T_WAIT)
  `ASSERT_CLK(a_start_unit_idle, clk, rst, cmd.start |-> !stat.busy)
  `ASSERT_CLK(a_accept_unit_idle, clk, rst, in_ready |-> !stat.busy)
  `ASSERT_CLK(a_result_from_fin, clk, rst, (out_valid && !$past(out_valid)) |-> $past(state) == T_FIN)

endmodule
